[hw/rtl/sbl_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package sbl_pkg;

    // Pixel and arithmetic widths
    localparam int PIX_W = 8;
    localparam int SUM_W = 10;              // 1-2-1 weighted column/row sum
    localparam int MAG_W = 10;              // absolute gradient
    localparam int SQ_W  = 20;              // squared gradient
    localparam int THR_W = 21;              // threshold and magnitude sum

    // Decoupling queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = 3;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_EDGE_THRESHOLD = 1'b0;

    // Gradient summary handed from front to back
    typedef struct packed {
        logic             interior;
        logic [MAG_W-1:0] gx_abs;
        logic [MAG_W-1:0] gy_abs;
    } grad_t;

endpackage

`default_nettype wire

[hw/rtl/sbl_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module sbl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 80
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read, old data on a same-address write
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[hw/rtl/sbl_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module sbl_front #(
    parameter int IMAGE_WIDTH  = 80,
    parameter int IMAGE_HEIGHT = 60
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            pixel_valid,
    output logic                                 pixel_stall,
    input  wire logic [sbl_pkg::PIX_W-1:0]       pixel,
    input  wire logic                            frame_start,
    input  wire logic [sbl_pkg::QCNT_W-1:0]      queue_count,
    output logic                                 push,
    output sbl_pkg::grad_t                       push_grad,
    output logic [$clog2(IMAGE_HEIGHT)-1:0]      push_row,
    output logic [$clog2(IMAGE_WIDTH)-1:0]       push_col
);

    localparam int ROW_W = $clog2(IMAGE_HEIGHT);
    localparam int COL_W = $clog2(IMAGE_WIDTH);
    localparam int PW    = sbl_pkg::PIX_W;
    localparam int SW    = sbl_pkg::SUM_W;

    // Position counters
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] r_cur;
    logic [COL_W-1:0] c_cur;
    logic             accept;

    // Stage 1: pixel whose line-store read is in flight
    logic             s1_valid_reg;
    logic [PW-1:0]    s1_px_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic             s1_emit_reg;
    logic             s1_interior_reg;
    logic [ROW_W-1:0] s1_crow_reg;
    logic [COL_W-1:0] s1_ccol_reg;
    logic             s1_byp_reg;
    logic [2*PW-1:0]  s1_byp_data_reg;

    // Window: [0..2] column c-1 (top, mid, bottom), [3..5] column c-2
    logic [PW-1:0]    win_reg [6];

    logic [2*PW-1:0]  ram_rdata;
    logic [2*PW-1:0]  line_data;
    logic [PW-1:0]    top;
    logic [PW-1:0]    mid;
    logic [SW-1:0]    left_sum;
    logic [SW-1:0]    right_sum;
    logic [SW-1:0]    upper_sum;
    logic [SW-1:0]    lower_sum;

    // Hold input while the queue could not absorb the items in flight
    assign pixel_stall = ({1'b0, queue_count} + {{sbl_pkg::QCNT_W{1'b0}}, s1_valid_reg})
                         >= (sbl_pkg::QCNT_W+1)'(sbl_pkg::QUEUE_DEPTH);
    assign accept      = pixel_valid && !pixel_stall;

    // Restart position on frame start
    assign r_cur = frame_start ? '0 : row_reg;
    assign c_cur = frame_start ? '0 : col_reg;

    // Advance raster position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            if (c_cur == COL_W'(IMAGE_WIDTH - 1))
            begin
                col_reg <= '0;
                row_reg <= (r_cur == ROW_W'(IMAGE_HEIGHT - 1)) ? '0 : r_cur + 1'b1;
            end
            else
            begin
                col_reg <= c_cur + 1'b1;
                row_reg <= r_cur;
            end
        end
    end

    // Line stores: low byte row r-2, high byte row r-1
    sbl_ram #(
        .WIDTH (2 * PW),
        .DEPTH (IMAGE_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata ({s1_px_reg, mid}),
        .raddr (c_cur),
        .rdata (ram_rdata)
    );

    // Forward the write of the previous pixel when it hits the same column
    assign line_data = s1_byp_reg ? s1_byp_data_reg : ram_rdata;
    assign top       = line_data[PW-1:0];
    assign mid       = line_data[2*PW-1:PW];

    // Classify and capture the accepted pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_px_reg       <= pixel;
        s1_col_reg      <= c_cur;
        s1_emit_reg     <= (r_cur != '0) && (c_cur != '0);
        s1_interior_reg <= (r_cur >= ROW_W'(2)) && (c_cur >= COL_W'(2));
        s1_crow_reg     <= r_cur - 1'b1;
        s1_ccol_reg     <= c_cur - 1'b1;
        s1_byp_reg      <= s1_valid_reg && (c_cur == s1_col_reg);
        s1_byp_data_reg <= {s1_px_reg, mid};
    end

    // Shift the window by one column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (s1_valid_reg)
        begin
            win_reg[3] <= win_reg[0];
            win_reg[4] <= win_reg[1];
            win_reg[5] <= win_reg[2];
            win_reg[0] <= top;
            win_reg[1] <= mid;
            win_reg[2] <= s1_px_reg;
        end
    end

    // Weighted 1-2-1 sums of the window edges
    assign right_sum = SW'(top) + {1'b0, mid, 1'b0} + SW'(s1_px_reg);
    assign left_sum  = SW'(win_reg[3]) + {1'b0, win_reg[4], 1'b0} + SW'(win_reg[5]);
    assign upper_sum = SW'(win_reg[3]) + {1'b0, win_reg[0], 1'b0} + SW'(top);
    assign lower_sum = SW'(win_reg[5]) + {1'b0, win_reg[2], 1'b0} + SW'(s1_px_reg);

    // Absolute gradients go to the queue
    always_comb
    begin
        push_grad.interior = s1_interior_reg;
        push_grad.gx_abs   = (right_sum >= left_sum) ? right_sum - left_sum
                                                     : left_sum - right_sum;
        push_grad.gy_abs   = (upper_sum >= lower_sum) ? upper_sum - lower_sum
                                                      : lower_sum - upper_sum;
    end

    assign push     = s1_valid_reg && s1_emit_reg;
    assign push_row = s1_crow_reg;
    assign push_col = s1_ccol_reg;

endmodule

`default_nettype wire

[hw/rtl/sbl_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module sbl_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire logic [WIDTH-1:0]           push_data,
    input  wire logic                       pop,
    output logic      [WIDTH-1:0]           pop_data,
    output logic      [$clog2(DEPTH+1)-1:0] count
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    // Store pushed entry
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    assign pop_data = entry_reg[rd_ptr_reg];
    assign count    = count_reg;

endmodule

`default_nettype wire

[hw/rtl/sbl_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module sbl_back #(
    parameter int ROW_W = 6,
    parameter int COL_W = 7
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic [sbl_pkg::THR_W-1:0]   edge_threshold,
    input  wire logic                        pop_avail,
    output logic                             pop,
    input  wire sbl_pkg::grad_t              pop_grad,
    input  wire logic [ROW_W-1:0]            pop_row,
    input  wire logic [COL_W-1:0]            pop_col,
    output logic                             result_valid,
    input  wire logic                        result_stall,
    output logic                             edge_res,
    output logic [ROW_W-1:0]                 out_row,
    output logic [COL_W-1:0]                 out_col
);

    localparam int QW = sbl_pkg::SQ_W;
    localparam int TW = sbl_pkg::THR_W;

    // Square stage
    logic             b1_valid_reg;
    logic [QW-1:0]    b1_sqx_reg;
    logic [QW-1:0]    b1_sqy_reg;
    logic             b1_interior_reg;
    logic [ROW_W-1:0] b1_row_reg;
    logic [COL_W-1:0] b1_col_reg;

    // Output register
    logic             out_valid_reg;
    logic             edge_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;

    logic             out_adv;
    logic             b1_adv;
    logic [TW-1:0]    mag;

    assign out_adv = !out_valid_reg || !result_stall;
    assign b1_adv  = !b1_valid_reg || out_adv;
    assign pop     = pop_avail && b1_adv;

    // Square both gradients
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
        end
        else if (b1_adv)
        begin
            b1_valid_reg <= pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            b1_sqx_reg      <= QW'(pop_grad.gx_abs) * QW'(pop_grad.gx_abs);
            b1_sqy_reg      <= QW'(pop_grad.gy_abs) * QW'(pop_grad.gy_abs);
            b1_interior_reg <= pop_grad.interior;
            b1_row_reg      <= pop_row;
            b1_col_reg      <= pop_col;
        end
    end

    // Sum and compare against the threshold
    assign mag = {1'b0, b1_sqx_reg} + {1'b0, b1_sqy_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_adv)
        begin
            out_valid_reg <= b1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && b1_valid_reg)
        begin
            edge_reg <= b1_interior_reg && (mag > edge_threshold);
            row_reg  <= b1_row_reg;
            col_reg  <= b1_col_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign edge_res     = edge_reg;
    assign out_row      = row_reg;
    assign out_col      = col_reg;

endmodule

`default_nettype wire

[hw/rtl/sobel_edge_threshold.sv]
// A result passes the stage-1, queue, square and output registers after its pixel transfer.
// Throughput: one pixel per cycle unless stalled; the line store is a single dual-port RAM
// with one read and one write each cycle, and a 4-entry queue lets the output side stall on its own.
// Pixels in the first row and column produce no result; all others produce exactly one.
// Reset (rst_n, asynchronous, active low) clears the position counters, window, queue,
// pipeline valids and the threshold; line-store contents are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module sobel_edge_threshold #(
    parameter int IMAGE_WIDTH  = 80,
    parameter int IMAGE_HEIGHT = 60
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // Pixel channel
    input  wire logic                                 pixel_valid,
    output logic                                      pixel_stall,
    input  wire logic [sbl_pkg::PIX_W-1:0]            pixel,
    input  wire logic                                 frame_start,
    // Result channel
    output logic                                      result_valid,
    input  wire logic                                 result_stall,
    output logic                                      edge_res,
    output logic [$clog2(IMAGE_HEIGHT)-1:0]           out_row,
    output logic [$clog2(IMAGE_WIDTH)-1:0]            out_col,
    // Configuration port
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [sbl_pkg::APB_ADDR_W-1:0]       paddr,
    input  wire logic [sbl_pkg::APB_DATA_W-1:0]       pwdata,
    output logic      [sbl_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                      pready
);

    localparam int ROW_W = $clog2(IMAGE_HEIGHT);
    localparam int COL_W = $clog2(IMAGE_WIDTH);
    localparam int GW    = $bits(sbl_pkg::grad_t);
    localparam int QDW   = GW + ROW_W + COL_W;

    logic [sbl_pkg::THR_W-1:0]  thr_reg;
    logic                       cfg_write;

    logic                       push;
    sbl_pkg::grad_t             push_grad;
    logic [ROW_W-1:0]           push_row;
    logic [COL_W-1:0]           push_col;
    logic                       pop;
    logic [QDW-1:0]             pop_data;
    logic [sbl_pkg::QCNT_W-1:0] queue_count;
    sbl_pkg::grad_t             pop_grad;

    // Configuration write and readback
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (cfg_write && (paddr[2] == sbl_pkg::REG_EDGE_THRESHOLD))
        begin
            thr_reg <= pwdata[sbl_pkg::THR_W-1:0];
        end
    end

    assign prdata = (paddr[2] == sbl_pkg::REG_EDGE_THRESHOLD)
                    ? sbl_pkg::APB_DATA_W'(thr_reg) : '0;

    // Front: position, line stores, window, gradients
    sbl_front #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .frame_start (frame_start),
        .queue_count (queue_count),
        .push        (push),
        .push_grad   (push_grad),
        .push_row    (push_row),
        .push_col    (push_col)
    );

    // Decoupling queue
    sbl_queue #(
        .WIDTH (QDW),
        .DEPTH (sbl_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_grad, push_row, push_col}),
        .pop       (pop),
        .pop_data  (pop_data),
        .count     (queue_count)
    );

    assign pop_grad = pop_data[QDW-1:ROW_W+COL_W];

    // Back: magnitude, threshold, output register
    sbl_back #(
        .ROW_W (ROW_W),
        .COL_W (COL_W)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .edge_threshold (thr_reg),
        .pop_avail      (queue_count != '0),
        .pop            (pop),
        .pop_grad       (pop_grad),
        .pop_row        (pop_data[ROW_W+COL_W-1:COL_W]),
        .pop_col        (pop_data[COL_W-1:0]),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .edge_res       (edge_res),
        .out_row        (out_row),
        .out_col        (out_col)
    );

    // Queue never overfills
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        queue_count <= sbl_pkg::QCNT_W'(sbl_pkg::QUEUE_DEPTH))
        else $error("decoupling queue overflow");

    // Input is held whenever the queue is full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        (queue_count == sbl_pkg::QCNT_W'(sbl_pkg::QUEUE_DEPTH)) |-> pixel_stall)
        else $error("pixel accepted with full queue");

    // Last row and column are never reported as centers
    a_center_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((out_row < ROW_W'(IMAGE_HEIGHT - 1))
                          && (out_col < COL_W'(IMAGE_WIDTH - 1))))
        else $error("result center outside emitted range");

    // Border centers never carry an edge
    a_border_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && edge_res) |-> ((out_row != '0) && (out_col != '0)))
        else $error("edge reported on frame border");

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int IMG_W = 80;
    localparam int IMG_H = 60;
    localparam int ROW_W = $clog2(IMG_H);
    localparam int COL_W = $clog2(IMG_W);
    localparam int PW = sbl_pkg::PIX_W;
    localparam int AW = sbl_pkg::APB_ADDR_W;
    localparam int DW = sbl_pkg::APB_DATA_W;
    localparam int TW = sbl_pkg::THR_W;
    localparam int LONGEST_WAIT = 17;
    localparam int DRAIN_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 10;

    // Register map: threshold at index 0, index 1 is unmapped
    localparam logic [AW-1:0] THR_ADDR = {sbl_pkg::REG_EDGE_THRESHOLD, 2'b00};
    localparam logic [AW-1:0] UNMAPPED_ADDR = {1'b1, 2'b00};

    // Pixel content styles
    localparam int STYLE_NOISE = 0;
    localparam int STYLE_BINARY = 1;
    localparam int STYLE_RAMP = 2;
    localparam int STYLE_FLAT = 3;

    typedef struct {
        logic [PW-1:0] value;
        logic          fs;
    } pix_item_t;

    typedef struct {
        logic             edge_bit;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } edge_rec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic          pixel_valid = 1'b0;
    logic          pixel_stall;
    logic [PW-1:0] pixel = '0;
    logic          frame_start = 1'b0;
    logic          result_valid;
    logic          result_stall = 1'b0;
    logic          edge_res;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [AW-1:0] paddr = '0;
    logic [DW-1:0] pwdata = '0;
    logic [DW-1:0] prdata;
    logic          pready;

    sobel_edge_threshold #(
        .IMAGE_WIDTH  (IMG_W),
        .IMAGE_HEIGHT (IMG_H)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .frame_start  (frame_start),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .edge_res     (edge_res),
        .out_row      (out_row),
        .out_col      (out_col),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Pending pixels and expected edge results
    pix_item_t pix_q[$];
    edge_rec_t edge_q[$];
    int fail_cnt = 0;

    // Directed pixels: extremes, frame start on the first pixel and mid-row
    logic [PW-1:0] dir_px[16] = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h01, 8'hFE,
                                  8'h80, 8'h7F, 8'h55, 8'hAA, 8'hAA, 8'h55,
                                  8'hFF, 8'h00, 8'h00, 8'hFF};
    logic dir_fs[16] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                         1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

    // Mirror of the detector state
    logic [PW-1:0] line_prev[IMG_W] = '{default: '0};
    logic [PW-1:0] line_prev2[IMG_W] = '{default: '0};
    logic [PW-1:0] win[6] = '{default: '0};
    int unsigned pos_row = 0;
    int unsigned pos_col = 0;
    logic [TW-1:0] edge_thr = '0;

    // Idle pacing on each side
    bit send_calm = 1'b0;
    bit recv_calm = 1'b1;
    int gap_left = 0;
    int stall_left = 0;

    initial begin
        forever #2 clk = ~clk;
    end

    // Give up after a generous fixed time
    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Toggle between stretches without idling and random waits
    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, LONGEST_WAIT);
    endfunction

    function automatic void flag(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] act_v);
        fail_cnt++;
        $error("%s: expected %0d, actual %0d", what, exp_v, act_v);
    endfunction

    // Advance the mirror by one pixel and queue the result it causes
    function automatic void predict_edge(input logic [PW-1:0] px, input logic fs);
        int unsigned r;
        int unsigned c;
        int unsigned cr;
        int unsigned cc;
        logic [PW-1:0] top;
        logic [PW-1:0] mid;
        int gx;
        int gy;
        int unsigned mag;
        edge_rec_t rec;

        if (fs) begin
            pos_row = 0;
            pos_col = 0;
        end
        r = pos_row;
        c = pos_col;
        top = line_prev2[c];
        mid = line_prev[c];

        if (r >= 1 && c >= 1) begin
            cr = r - 1;
            cc = c - 1;
            rec.edge_bit = 1'b0;
            // interior centers only; border centers stay zero
            if (cr >= 1 && cc >= 1 && cr < IMG_H - 1 && cc < IMG_W - 1) begin
                gx = (int'(top) + 2 * int'(mid) + int'(px))
                   - (int'(win[3]) + 2 * int'(win[4]) + int'(win[5]));
                gy = (int'(win[3]) + 2 * int'(win[0]) + int'(top))
                   - (int'(win[5]) + 2 * int'(win[2]) + int'(px));
                mag = gx * gx + gy * gy;
                rec.edge_bit = (mag > edge_thr);
            end
            rec.row = ROW_W'(cr);
            rec.col = COL_W'(cc);
            edge_q.push_back(rec);
        end

        // shift the window left, then write the line stores
        win[3] = win[0];
        win[4] = win[1];
        win[5] = win[2];
        win[0] = top;
        win[1] = mid;
        win[2] = px;
        line_prev2[c] = mid;
        line_prev[c] = px;

        c++;
        if (c >= IMG_W) begin
            c = 0;
            r++;
            if (r >= IMG_H)
                r = 0;
        end
        pos_row = r;
        pos_col = c;
    endfunction

    // Pixel driver: predict on each transfer, then present the next pixel
    always @(posedge clk or negedge rst_n) begin
        pix_item_t cur;
        if (!rst_n) begin
            pixel_valid <= 1'b0;
            pixel <= '0;
            frame_start <= 1'b0;
            gap_left = 0;
        end else begin
            if (pixel_valid && !pixel_stall)
                predict_edge(pixel, frame_start);
            if (!pixel_valid || !pixel_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    pixel_valid <= 1'b0;
                end else if (pix_q.size() != 0) begin
                    cur = pix_q.pop_front();
                    pixel_valid <= 1'b1;
                    pixel <= cur.value;
                    frame_start <= cur.fs;
                    gap_left = draw_wait(send_calm);
                end else begin
                    pixel_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each transfer with the oldest expectation
    always @(posedge clk or negedge rst_n) begin
        edge_rec_t exp_rec;
        if (!rst_n) begin
            result_stall <= 1'b0;
            stall_left = 0;
        end else begin
            if (result_valid && !result_stall) begin
                if (edge_q.size() == 0) begin
                    fail_cnt++;
                    $error("result with none pending: row %0d col %0d", out_row, out_col);
                end else begin
                    exp_rec = edge_q.pop_front();
                    if (edge_res !== exp_rec.edge_bit)
                        flag("edge_res", exp_rec.edge_bit, edge_res);
                    if (out_row !== exp_rec.row)
                        flag("out_row", exp_rec.row, out_row);
                    if (out_col !== exp_rec.col)
                        flag("out_col", exp_rec.col, out_col);
                end
                stall_left = draw_wait(recv_calm);
            end else if (stall_left > 0) begin
                stall_left--;
            end
            result_stall <= (stall_left != 0);
        end
    end

    // One register transfer: setup, then access until pready
    task automatic apb_xfer(input logic wr, input logic [AW-1:0] addr,
                            input logic [DW-1:0] wdata,
                            output logic [DW-1:0] rdata);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_threshold();
        logic [DW-1:0] rd;
        apb_xfer(1'b0, THR_ADDR, '0, rd);
        if (rd !== DW'(edge_thr))
            flag("edge_threshold readback", edge_thr, rd);
    endtask

    // Wait for all pixels and results, then let the pipeline empty
    task automatic settle();
        int waited;
        while (pix_q.size() != 0 || pixel_valid)
            @(posedge clk);
        waited = 0;
        while (edge_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_threshold(input logic [DW-1:0] wval);
        logic [DW-1:0] rd;
        settle();
        apb_xfer(1'b1, THR_ADDR, wval, rd);
        edge_thr = wval[TW-1:0];
        check_threshold();
    endtask

    function automatic logic [PW-1:0] make_pixel(input int style, input int idx);
        case (style)
            STYLE_NOISE:  return PW'($urandom_range(0, 255));
            STYLE_BINARY: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            STYLE_RAMP:   return PW'((idx % IMG_W) * 3 + $urandom_range(0, 6));
            default:      return ($urandom_range(0, 15) == 0) ? PW'($urandom) : 8'd100;
        endcase
    endfunction

    // Queue one frame of n pixels; content style changes at row starts
    task automatic queue_frame(input int n, input bit with_start, input bit noisy);
        int style;
        pix_item_t it;
        style = $urandom_range(STYLE_NOISE, STYLE_FLAT);
        for (int i = 0; i < n; i++) begin
            if (i % IMG_W == 0)
                style = $urandom_range(STYLE_NOISE, STYLE_FLAT);
            it.fs = (with_start && i == 0) || (noisy && $urandom_range(0, 499) == 0);
            it.value = make_pixel(style, i);
            pix_q.push_back(it);
        end
    endtask

    // A partial frame deep enough to reach interior centers, and a short one
    task automatic queue_partial_frames();
        queue_frame($urandom_range(2 * IMG_W + 10, 2 * IMG_W + 70), 1'b1, 1'b1);
        queue_frame($urandom_range(1, IMG_W / 2), 1'b1, 1'b1);
    endtask

    initial begin
        logic [DW-1:0] rd;
        pix_item_t it;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: pixel extremes, frame start on the first pixel and mid-row
        for (int i = 0; i < 16; i++) begin
            it.value = dir_px[i];
            it.fs = dir_fs[i];
            pix_q.push_back(it);
        end

        // Zero threshold: any nonzero gradient is an edge
        set_threshold('0);
        queue_partial_frames();

        // All ones: upper bits dropped; then the largest possible magnitude
        set_threshold('1);
        set_threshold(32'd2080800);
        queue_partial_frames();

        // Small threshold
        set_threshold($urandom_range(0, 300));
        queue_partial_frames();

        // Random value with random upper bits
        set_threshold($urandom);
        queue_partial_frames();

        // Write to an unmapped register leaves the threshold alone
        set_threshold($urandom_range(1000, 300000));
        settle();
        apb_xfer(1'b1, UNMAPPED_ADDR, $urandom, rd);
        check_threshold();
        queue_partial_frames();

        settle();
        if (edge_q.size() != 0)
            flag("results left pending", 0, edge_q.size());

        if (fail_cnt == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/sbl_pkg.sv
hw/rtl/sbl_ram.sv
hw/rtl/sbl_front.sv
hw/rtl/sbl_queue.sv
hw/rtl/sbl_back.sv
hw/rtl/sobel_edge_threshold.sv
sim/tb_top.sv
